// ===== src/binom_pkg.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient package
// Shared state encoding and the starting row of Pascal's triangle.
// ----------------------------------------------------------------------------
`default_nettype none

package binom_pkg;

  localparam int unsigned CoefW = 64;
  localparam int unsigned ArgW  = 6;

  // Row 4 of Pascal's triangle is the first row that is built into the store.
  localparam logic [ArgW-1:0]  FirstRow = 6'd4;
  localparam logic [CoefW-1:0] StartC42 = 64'd6;
  localparam logic [CoefW-1:0] StartC43 = 64'd4;
  localparam logic [CoefW-1:0] StartC44 = 64'd1;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StSweep,
    StDrain,
    StFetch,
    StCapture,
    StOut
  } state_e;

  // Starting entry C(4, idx+2); entries past the end of row 4 are zero.
  function automatic logic [CoefW-1:0] start_entry(input logic [ArgW-1:0] idx);
    logic [CoefW-1:0] val;
    case (idx)
      6'd0:    val = StartC42;
      6'd1:    val = StartC43;
      6'd2:    val = StartC44;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== src/binomial_coefficient_pascal_core.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient core
// Exact 64-bit C(n,k) built row by row in a Pascal row store.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one request word with n in tdata[5:0] and k
// in tdata[11:6]. The master channel returns one word per request with the
// coefficient in tdata[63:0] and the bad-request flag in tuser.
// The core handles one request at a time; s_axis_tready_o is high only while
// it is idle. Trivial requests (k > n, n > MAX_N, n < 2, k = 0 or 1 after
// folding k to min(k, n-k)) go straight to the output stage. Other requests
// load k-1 entries, then sweep rows 4 .. n-1 through one shared 64-bit adder
// and one RAM read port, and read the answer from the last entry. The RAM is
// read each cycle of a sweep, which sets the rate, and each entry read is
// written back in place. A finished result sits in the output register until
// the receiver takes it; while the receiver stalls, the core can still take
// and compute one more request, then holds that result and accepts nothing.
// Reset returns the sequencer to idle and empties the output register. The
// row RAM needs no clearing: every entry read is first loaded by the request.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient_pascal_core
  import binom_pkg::*;
#(
  parameter int unsigned MAX_N = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Fields from bit 0 up: n_total [5:0], k_chosen [11:6], zero pad [15:12].
  input  wire logic [15:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0 up: coefficient [63:0].
  output logic [63:0]      m_axis_tdata_o,
  // Fields from bit 0 up: bad_request [0].
  output logic             m_axis_tuser_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i
);

  // The row store holds C(r, j+2) for j = 0 .. k-2.
  localparam int unsigned RowCap = MAX_N / 2;
  localparam int unsigned IdxW   = $clog2(RowCap);

  state_e state_q, state_d;

  logic [ArgW-1:0]  n_q, n_d;
  logic [ArgW-1:0]  r_q, r_d;
  logic [IdxW-1:0]  last_q, last_d;
  logic [IdxW-1:0]  j_q, j_d;
  logic [IdxW-1:0]  wj_q, wj_d;
  logic             rd_vld_q, rd_vld_d;
  logic [CoefW-1:0] prev_q, prev_d;
  logic [CoefW-1:0] res_q, res_d;
  logic             bad_q, bad_d;
  logic             out_vld_q, out_vld_d;
  logic [CoefW-1:0] out_data_q, out_data_d;
  logic             out_bad_q, out_bad_d;

  // Row RAM, one write and one registered read port.
  logic [CoefW-1:0] row_mem [RowCap];
  logic [CoefW-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_wa, mem_ra;
  logic [CoefW-1:0] mem_wd;

  // Request decode.
  logic [ArgW-1:0]  req_n, req_k, req_nk, req_kf;
  logic             req_bad;

  // Shared adder.
  logic [CoefW-1:0] add_b, add_sum;

  logic             in_fire;
  logic             out_free;

  assign req_n   = s_axis_tdata_i[5:0];
  assign req_k   = s_axis_tdata_i[11:6];
  assign req_nk  = req_n - req_k;
  assign req_kf  = (req_nk < req_k) ? req_nk : req_k;
  assign req_bad = (req_k > req_n) || ({1'b0, req_n} > 7'(MAX_N));

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Entry 0 takes the row number r, since C(r,1) = r; the others take the
  // old value of their left neighbor, kept from the previous read.
  assign add_b   = (wj_q == '0) ? {{(CoefW-ArgW){1'b0}}, r_q} : prev_q;
  assign add_sum = rdata_q + add_b;

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_bad_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (req_bad || req_n < 6'd2 || req_kf < 6'd2) begin
            state_d = StOut;
          end else begin
            state_d = StLoad;
          end
        end
      end
      StLoad: begin
        if (j_q == last_q) begin
          state_d = (n_q == FirstRow) ? StFetch : StSweep;
        end
      end
      StSweep: begin
        if (j_q == last_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = ((r_q + 6'd1) == n_q) ? StFetch : StSweep;
      end
      StFetch:   state_d = StCapture;
      StCapture: state_d = StOut;
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default:   state_d = StIdle;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    n_d        = n_q;
    r_d        = r_q;
    last_d     = last_q;
    j_d        = j_q;
    wj_d       = j_q;
    rd_vld_d   = 1'b0;
    prev_d     = prev_q;
    res_d      = res_q;
    bad_d      = bad_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    out_bad_d  = out_bad_q;
    mem_re     = 1'b0;
    mem_ra     = j_q;
    mem_we     = 1'b0;
    mem_wa     = wj_q;
    mem_wd     = add_sum;

    // A read issued last cycle comes back now and is written in place.
    if (rd_vld_q) begin
      mem_we = 1'b1;
      prev_d = rdata_q;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          n_d    = req_n;
          r_d    = FirstRow;
          j_d    = '0;
          last_d = IdxW'(req_kf - 6'd2);
          bad_d  = req_bad;
          if (req_bad) begin
            res_d = '0;
          end else if (req_n < 6'd2 || req_kf == 6'd0) begin
            res_d = 64'd1;
          end else begin
            res_d = {{(CoefW-ArgW){1'b0}}, req_n};
          end
        end
      end
      StLoad: begin
        mem_we = 1'b1;
        mem_wa = j_q;
        mem_wd = start_entry(ArgW'(j_q));
        j_d    = (j_q == last_q) ? '0 : j_q + 1'b1;
      end
      StSweep: begin
        mem_re   = 1'b1;
        rd_vld_d = 1'b1;
        j_d      = (j_q == last_q) ? '0 : j_q + 1'b1;
      end
      StDrain: begin
        r_d = r_q + 6'd1;
      end
      StFetch: begin
        mem_re = 1'b1;
        mem_ra = last_q;
      end
      StCapture: begin
        res_d = rdata_q;
        bad_d = 1'b0;
      end
      StOut: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = res_q;
          out_bad_d  = bad_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    r_q        <= r_d;
    last_q     <= last_d;
    j_q        <= j_d;
    wj_q       <= wj_d;
    prev_q     <= prev_d;
    res_q      <= res_d;
    bad_q      <= bad_d;
    out_data_q <= out_data_d;
    out_bad_q  <= out_bad_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= row_mem[mem_ra];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient core testbench
// Sends (n, k) request words to the core and checks every returned C(n,k)
// word and its bad-request flag against a Pascal-row predictor or a written
// answer. A directed table covers the argument extremes, k greater than n,
// folding of k to n-k, the trivial answers and the short starting rows.
// Random requests follow, mostly small and well formed, with full-range,
// out-of-range and a few large sweeps mixed in. Random bursts of idle cycles
// are inserted on both sides, and one long output stall backs up the input.
// ----------------------------------------------------------------------------

module tb;
  import binom_pkg::*;

  localparam int unsigned MaxN        = 63;
  localparam int unsigned RowCap      = MaxN / 2;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned CalmItems   = 60;   // final items sent with no idling
  localparam int unsigned HoldAtItem  = 200;  // random item that starts the long stall
  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned SettleCycles = 64;
  // Longest correct silence: a full sweep, the long stall and two idle bursts.
  // The limit takes that several times over.
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned DirRows     = 25;

  typedef struct packed {
    logic [CoefW-1:0] coef;
    logic             bad;
  } answer_t;

  typedef struct packed {
    logic [ArgW-1:0]  n;
    logic [ArgW-1:0]  k;
    logic             known;  // expected answer written in the row
    logic [CoefW-1:0] coef;
    logic             bad;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;

  answer_t     answers_due [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  // Rows marked known carry an answer that follows at once from the
  // arguments; the others are checked against the predictor.
  probe_t directed_rows [DirRows] = '{
    '{6'd0,  6'd0,  1'b1, 64'd1,  1'b0},  // first word after reset
    '{6'd63, 6'd63, 1'b1, 64'd1,  1'b0},
    '{6'd0,  6'd63, 1'b1, 64'd0,  1'b1},  // k greater than n
    '{6'd62, 6'd63, 1'b1, 64'd0,  1'b1},
    '{6'd0,  6'd1,  1'b1, 64'd0,  1'b1},
    '{6'd1,  6'd0,  1'b1, 64'd1,  1'b0},
    '{6'd1,  6'd1,  1'b1, 64'd1,  1'b0},
    '{6'd2,  6'd1,  1'b1, 64'd2,  1'b0},
    '{6'd2,  6'd2,  1'b1, 64'd1,  1'b0},
    '{6'd63, 6'd0,  1'b1, 64'd1,  1'b0},
    '{6'd63, 6'd1,  1'b1, 64'd63, 1'b0},
    '{6'd63, 6'd62, 1'b1, 64'd63, 1'b0},  // k folds to 1
    '{6'd4,  6'd2,  1'b1, 64'd6,  1'b0},  // one starting entry, no sweep
    '{6'd5,  6'd2,  1'b0, 64'd0,  1'b0},
    '{6'd5,  6'd3,  1'b0, 64'd0,  1'b0},
    '{6'd6,  6'd3,  1'b0, 64'd0,  1'b0},  // two starting entries
    '{6'd7,  6'd3,  1'b0, 64'd0,  1'b0},
    '{6'd8,  6'd4,  1'b0, 64'd0,  1'b0},  // all three starting entries
    '{6'd9,  6'd4,  1'b0, 64'd0,  1'b0},
    '{6'd10, 6'd6,  1'b0, 64'd0,  1'b0},
    '{6'd12, 6'd5,  1'b0, 64'd0,  1'b0},  // row longer than the start entries
    '{6'd42, 6'd21, 1'b0, 64'd0,  1'b0},
    '{6'd62, 6'd31, 1'b0, 64'd0,  1'b0},
    '{6'd63, 6'd31, 1'b0, 64'd0,  1'b0},  // largest sweep
    '{6'd63, 6'd32, 1'b0, 64'd0,  1'b0}
  };

  always #10 clk_i = ~clk_i;

  binomial_coefficient_pascal_core #(
    .MAX_N(MaxN)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  // Exact C(n,k) built from row 4 of Pascal's triangle, one row per pass.
  // row[j] holds C(r, j+2) for the row r being built.
  function automatic answer_t pascal_coefficient(input logic [ArgW-1:0] n_arg,
                                                 input logic [ArgW-1:0] k_arg);
    logic [CoefW-1:0] row [RowCap];
    int unsigned n;
    int unsigned k;
    int unsigned used;
    answer_t ans;
    n = n_arg;
    k = k_arg;
    ans.coef = '0;
    ans.bad = 1'b0;
    if (k > n || n > MaxN) begin
      ans.bad = 1'b1;
      return ans;
    end
    if (n - k < k) k = n - k;
    if (n < 2 || k == 0) begin
      ans.coef = 64'd1;
      return ans;
    end
    if (k == 1) begin
      ans.coef = CoefW'(n);
      return ans;
    end
    used = (k - 1 > RowCap) ? RowCap : k - 1;
    for (int j = 0; j < RowCap; j++) row[j] = '0;
    // Short rows take only the starting entries that fit.
    row[0] = StartC42;
    if (used >= 2) row[1] = StartC43;
    if (used >= 3) row[2] = StartC44;
    for (int r = int'(FirstRow); r < int'(n); r++) begin
      for (int j = int'(used) - 1; j > 0; j--) row[j] = row[j] + row[j-1];
      row[0] = row[0] + CoefW'(r);
    end
    ans.coef = row[used-1];
    return ans;
  endfunction

  // Offers one request word, sometimes after an idle burst with noise on the
  // data lines, and records the expected answer once the word is taken.
  task automatic send_request(input logic [ArgW-1:0] n, input logic [ArgW-1:0] k,
                              input answer_t want);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= {4'b0000, 12'($urandom)};
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i <= {4'b0000, k, n};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    answers_due.push_back(want);
  endtask

  initial begin : stimulus
    answer_t     want;
    int unsigned pick;
    int unsigned nv;
    int unsigned kv;
    int unsigned half;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].known) begin
        want.coef = directed_rows[i].coef;
        want.bad = directed_rows[i].bad;
      end else begin
        want = pascal_coefficient(directed_rows[i].n, directed_rows[i].k);
      end
      send_request(directed_rows[i].n, directed_rows[i].k, want);
    end

    for (int unsigned item = 0; item < RandomItems; item++) begin
      if (item == HoldAtItem) hold_req = 1'b1;
      if (item == RandomItems - CalmItems) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // Small, well-formed requests keep the sweeps short.
        nv = $urandom_range(0, 20);
        kv = $urandom_range(0, nv);
      end else if (pick < 70) begin
        nv = $urandom_range(0, 62);
        kv = $urandom_range(nv + 1, 63);
      end else if (pick < 96) begin
        nv = $urandom_range(0, 63);
        kv = $urandom_range(0, 63);
      end else begin
        nv = $urandom_range(48, 63);
        half = nv / 2;
        kv = $urandom_range(half - 4, half + 4);
      end
      want = pascal_coefficient(ArgW'(nv), ArgW'(kv));
      send_request(ArgW'(nv), ArgW'(kv), want);
    end
    s_axis_tvalid_i <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Output side: ready runs in random stretches with short idle bursts, one
  // long hold-off that backs the core up, and no idling near the end.
  initial begin : result_sink
    int unsigned span;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        span = $urandom_range(1, 8);
        repeat (span - 1) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        span = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
        repeat (span - 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (answers_due.size() == 0) begin
        $error("result word with no request outstanding: coefficient %0d bad_request %0b",
               m_axis_tdata_o, m_axis_tuser_o);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tdata_o !== want.coef) begin
          $error("coefficient: expected %0d, actual %0d", want.coef, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== want.bad) begin
          $error("bad_request: expected %0b, actual %0b", want.bad, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
